// ===== sv/asr_pkg.sv =====
// Shared types and constants for the axis auto-repeat stepper.
`default_nettype none

package asr_pkg;

  // Step and direction codes share the two-bit signed encoding of the step output.
  typedef enum logic [1:0] {
    DIR_NONE = 2'b00,
    DIR_DOWN = 2'b01,
    DIR_UP   = 2'b11
  } dir_t;

  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int DELAY_BITS     = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LOW_THRESHOLD    = 3'd0,
    REG_HIGH_THRESHOLD   = 3'd1,
    REG_INVERT_AXIS      = 3'd2,
    REG_FIRST_DELAY_MS   = 3'd3,
    REG_REPEAT_PERIOD_MS = 3'd4
  } reg_index_t;

endpackage

`default_nettype wire

// ===== sv/asr_classify.sv =====
// Zone classifier: sorts one axis reading into up, down or neutral.
`default_nettype none

module asr_classify #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] low_threshold,
  input  logic [SAMPLE_BITS-1:0] high_threshold,
  input  logic                   invert_axis,
  output asr_pkg::dir_t          dir
);
  import asr_pkg::*;

  logic in_low;
  logic in_high;

  assign in_low  = (sample <= low_threshold);
  assign in_high = (sample >= high_threshold);

  // The zone that means up is tested first, so overlapping zones resolve to up.
  always_comb begin
    if (invert_axis) begin
      if (in_high)     dir = DIR_UP;
      else if (in_low) dir = DIR_DOWN;
      else             dir = DIR_NONE;
    end else begin
      if (in_low)       dir = DIR_UP;
      else if (in_high) dir = DIR_DOWN;
      else              dir = DIR_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== sv/asr_engine.sv =====
// Repeat engine: held direction, repeat phase and step timer.
`default_nettype none

module asr_engine #(
  parameter int TIME_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  logic                                resync,
  input  asr_pkg::dir_t                       dir,
  input  logic [TIME_BITS-1:0]                now_ms,
  input  logic [asr_pkg::DELAY_BITS-1:0]      first_delay_ms,
  input  logic [asr_pkg::DELAY_BITS-1:0]      repeat_period_ms,
  output asr_pkg::dir_t                       emit
);
  import asr_pkg::*;

  dir_t                 held_dir, held_dir_next;
  logic                 repeating, repeating_next;
  logic [TIME_BITS-1:0] last_time, last_time_next;
  logic [TIME_BITS-1:0] elapsed;
  logic                 delay_done;
  logic                 period_done;

  // Wrapping difference, modulo two to the TIME_BITS.
  assign elapsed     = now_ms - last_time;
  assign delay_done  = (elapsed >= TIME_BITS'(first_delay_ms));
  assign period_done = (elapsed >= TIME_BITS'(repeat_period_ms));

  always_comb begin
    held_dir_next  = held_dir;
    repeating_next = repeating;
    last_time_next = last_time;
    emit           = DIR_NONE;
    if (resync) begin
      held_dir_next  = DIR_NONE;
      repeating_next = 1'b0;
      last_time_next = now_ms;
    end else if (dir == DIR_NONE) begin
      held_dir_next  = DIR_NONE;
      repeating_next = 1'b0;
    end else if (dir != held_dir) begin
      held_dir_next  = dir;
      repeating_next = 1'b0;
      last_time_next = now_ms;
      emit           = dir;
    end else if (!repeating) begin
      if (delay_done) begin
        repeating_next = 1'b1;
        last_time_next = now_ms;
        emit           = dir;
      end
    end else if (period_done) begin
      last_time_next = now_ms;
      emit           = dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_dir  <= DIR_NONE;
      repeating <= 1'b0;
      last_time <= '0;
    end else if (fire) begin
      held_dir  <= held_dir_next;
      repeating <= repeating_next;
      last_time <= last_time_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/axis_auto_repeat_stepper.sv =====
// Top level of the axis auto-repeat stepper: channels, registers and pipeline.
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    sample, now_ms, resync
// result    out        out_valid / out_stall  step (signed, -1 up, +1 down, 0 none)
// config    in         cfg_we                 cfg_index, cfg_data
//
// Every item yields exactly one result item, which moves from the input register to the
// result register. A new item can be accepted in every cycle while the result side does not
// stall. The single repeat engine updates its state as an item moves to the result
// register. Synchronous reset clears the pipeline valid flags and the engine state and
// loads the register defaults. A stall on the result side holds the result register and
// then the input register; in_stall rises only while both are occupied.

module axis_auto_repeat_stepper #(
  parameter int SAMPLE_BITS = 12,
  parameter int TIME_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [SAMPLE_BITS-1:0]               sample,
  input  logic [TIME_BITS-1:0]                 now_ms,
  input  logic                                 resync,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [1:0]                    step,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [asr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [asr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import asr_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] LOW_RESET    = SAMPLE_BITS'(1000);
  localparam logic [SAMPLE_BITS-1:0] HIGH_RESET   = SAMPLE_BITS'(3000);
  localparam logic [DELAY_BITS-1:0]  DELAY_RESET  = DELAY_BITS'(400);
  localparam logic [DELAY_BITS-1:0]  PERIOD_RESET = DELAY_BITS'(150);

  // Configuration registers.
  logic [SAMPLE_BITS-1:0] low_threshold;
  logic [SAMPLE_BITS-1:0] high_threshold;
  logic                   invert_axis;
  logic [DELAY_BITS-1:0]  first_delay_ms;
  logic [DELAY_BITS-1:0]  repeat_period_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold    <= LOW_RESET;
      high_threshold   <= HIGH_RESET;
      invert_axis      <= 1'b0;
      first_delay_ms   <= DELAY_RESET;
      repeat_period_ms <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_THRESHOLD:    low_threshold    <= cfg_data[SAMPLE_BITS-1:0];
        REG_HIGH_THRESHOLD:   high_threshold   <= cfg_data[SAMPLE_BITS-1:0];
        REG_INVERT_AXIS:      invert_axis      <= cfg_data[0];
        REG_FIRST_DELAY_MS:   first_delay_ms   <= cfg_data;
        REG_REPEAT_PERIOD_MS: repeat_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. The item held here is evaluated against the engine state and
  // moves to the result register when that register is free or being drained.
  logic                   in_full;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [TIME_BITS-1:0]   in_now;
  logic                   in_resync;
  logic                   advance;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_sample <= sample;
      in_now    <= now_ms;
      in_resync <= resync;
    end
  end

  dir_t dir;
  dir_t emit;

  asr_classify #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_classify (
    .sample        (in_sample),
    .low_threshold (low_threshold),
    .high_threshold(high_threshold),
    .invert_axis   (invert_axis),
    .dir           (dir)
  );

  // The engine commits its state only when the item leaves the input register, so
  // the next item always sees the state this one leaves behind.
  asr_engine #(
    .TIME_BITS(TIME_BITS)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .fire            (advance),
    .resync          (in_resync),
    .dir             (dir),
    .now_ms          (in_now),
    .first_delay_ms  (first_delay_ms),
    .repeat_period_ms(repeat_period_ms),
    .emit            (emit)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      step <= emit;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_axis_auto_repeat_stepper.sv =====
// Self-checking testbench for the axis auto-repeat stepper with its own step predictor.
module tb_axis_auto_repeat_stepper;
  import asr_pkg::*;

  // Tracks the repeat engine and the register file, and holds the steps that are
  // still to come out of the block, oldest first.
  class step_scoreboard;
    logic [11:0] low_thr;
    logic [11:0] high_thr;
    logic        invert;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
    dir_t        held;
    logic        repeating;
    logic [31:0] last_time;
    dir_t        expected_steps[$];
    int          mismatches;

    function void reset_state();
      low_thr = 12'd1000;
      high_thr = 12'd3000;
      invert = 1'b0;
      first_delay = 16'd400;
      repeat_period = 16'd150;
      held = DIR_NONE;
      repeating = 1'b0;
      last_time = '0;
      expected_steps.delete();
      mismatches = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [15:0] data);
      case (idx)
        REG_LOW_THRESHOLD: low_thr = data[11:0];
        REG_HIGH_THRESHOLD: high_thr = data[11:0];
        REG_INVERT_AXIS: invert = data[0];
        REG_FIRST_DELAY_MS: first_delay = data;
        REG_REPEAT_PERIOD_MS: repeat_period = data;
        default: ;
      endcase
    endfunction

    // The zone that means up is tested first, so overlapping zones resolve to up.
    function dir_t zone_of(logic [11:0] s);
      if (invert) begin
        if (s >= high_thr) return DIR_UP;
        if (s <= low_thr) return DIR_DOWN;
      end else begin
        if (s <= low_thr) return DIR_UP;
        if (s >= high_thr) return DIR_DOWN;
      end
      return DIR_NONE;
    endfunction

    function void note_item(logic [11:0] s, logic [31:0] t, logic r);
      dir_t        zone;
      dir_t        emitted;
      logic [31:0] elapsed;
      emitted = DIR_NONE;
      if (r) begin
        held = DIR_NONE;
        repeating = 1'b0;
        last_time = t;
      end else begin
        zone = zone_of(s);
        elapsed = t - last_time;
        if (zone == DIR_NONE) begin
          held = DIR_NONE;
          repeating = 1'b0;
        end else if (zone != held) begin
          held = zone;
          repeating = 1'b0;
          last_time = t;
          emitted = zone;
        end else if (!repeating) begin
          if (elapsed >= {16'd0, first_delay}) begin
            repeating = 1'b1;
            last_time = t;
            emitted = zone;
          end
        end else if (elapsed >= {16'd0, repeat_period}) begin
          last_time = t;
          emitted = zone;
        end
      end
      expected_steps.push_back(emitted);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_step(logic [1:0] got);
      dir_t want;
      if (expected_steps.size() == 0) begin
        report($sformatf("step %0d arrived with no item waiting for it", $signed(got)));
      end else begin
        want = expected_steps.pop_front();
        if (got !== want)
          report($sformatf("step mismatch: expected %0d, got %0d",
                           $signed(want), $signed(got)));
      end
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [11:0]          sample = '0;
  logic [31:0]          now_ms = '0;
  logic                 resync = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [1:0]    step;
  logic                 cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  step_scoreboard sb;

  // Millisecond clock that the stimulus advances from item to item; it wraps freely.
  logic [31:0] stamp_ms;
  // When set, the sender or the receiver runs back to back with no idle cycles.
  bit          sender_busy;
  bit          receiver_busy;
  int          stall_left = 0;

  axis_auto_repeat_stepper dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .now_ms   (now_ms),
    .resync   (resync),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .step     (step),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Results are taken at the rising edge. Each accepted result draws the number of
  // cycles the receiver holds off before it takes the next one.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_step(step);
      stall_left = receiver_busy ? 0 : $urandom_range(0, 10);
    end
  end

  // The stall line changes only at the falling edge, away from the sampling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one item after a random gap (none while sender_busy is set) and returns at the
  // falling edge after the item is taken. The payload holds still while the block stalls.
  task automatic send_item(input logic [11:0] s, input logic [31:0] t, input logic r);
    int gap;
    gap = sender_busy ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    sample = s;
    now_ms = t;
    resync = r;
    do @(posedge clk); while (in_stall);
    sb.note_item(s, t, r);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Every item yields a result, so an empty expectation queue means the pipeline has drained.
  task automatic wait_idle();
    while (sb.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Reprograms the whole register file; only called while the block is drained.
  task automatic program_regs(input logic [11:0] lo, input logic [11:0] hi,
                              input logic inv, input logic [15:0] delay,
                              input logic [15:0] period);
    write_reg(REG_LOW_THRESHOLD, {4'd0, lo});
    write_reg(REG_HIGH_THRESHOLD, {4'd0, hi});
    write_reg(REG_INVERT_AXIS, {15'd0, inv});
    write_reg(REG_FIRST_DELAY_MS, delay);
    write_reg(REG_REPEAT_PERIOD_MS, period);
  endtask

  // Picks a reading from the low zone, the high zone, the band between them, or
  // anywhere on the scale.
  function automatic logic [11:0] pick_sample(int zone_kind);
    case (zone_kind)
      0: return 12'($urandom_range(0, sb.low_thr));
      1: return 12'($urandom_range(sb.high_thr, 4095));
      2: begin
        if (sb.high_thr > sb.low_thr + 1)
          return 12'($urandom_range(sb.low_thr + 1, sb.high_thr - 1));
        return 12'($urandom_range(0, 4095));
      end
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Time steps cluster around the programmed delay and period so that holds land on
  // both sides of every repeat boundary; now and then a jump spans the whole counter.
  function automatic logic [31:0] pick_advance();
    int unsigned span;
    span = (sb.first_delay > sb.repeat_period) ? sb.first_delay : sb.repeat_period;
    case ($urandom_range(0, 11))
      0: return 32'd0;
      1: return {16'd0, sb.first_delay};
      2: return {16'd0, sb.first_delay} - 32'd1;
      3: return {16'd0, sb.repeat_period};
      4: return {16'd0, sb.repeat_period} - 32'd1;
      5: return 32'($urandom_range(0, 20));
      6: return $urandom();
      default: return 32'($urandom_range(0, span + span / 4 + 2));
    endcase
  endfunction

  // Mostly holds of one zone with advancing time, which is what walks the engine
  // through its delay and repeat phases; neutral runs, random readings and resyncs
  // break the holds up.
  task automatic run_phase(input int count);
    int sent;
    int run_len;
    int zone_kind;
    sent = 0;
    sender_busy = ($urandom_range(0, 2) == 0);
    receiver_busy = ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 3) == 0) stamp_ms = $urandom();
    while (sent < count) begin
      zone_kind = $urandom_range(0, 9);
      if (zone_kind > 3) zone_kind = zone_kind & 1;
      run_len = $urandom_range(1, 12);
      repeat (run_len) begin
        stamp_ms = stamp_ms + pick_advance();
        send_item(pick_sample(zone_kind), stamp_ms, ($urandom_range(0, 29) == 0));
        sent++;
      end
    end
    sender_busy = 1'b0;
    receiver_busy = 1'b0;
  endtask

  initial begin
    sb = new;
    sb.reset_state();
    sender_busy = 1'b0;
    receiver_busy = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset defaults: a first press, the hold up to and past the first delay, one
    // repeat period across the counter wrap, thresholds hit exactly, a reversal,
    // a release, and a resync that clears the held direction.
    stamp_ms = 32'hFFFF_FE00;
    send_item(12'd0, stamp_ms, 1'b0);
    send_item(12'd0, stamp_ms + 32'd399, 1'b0);
    send_item(12'd1000, stamp_ms + 32'd400, 1'b0);
    send_item(12'd500, stamp_ms + 32'd549, 1'b0);
    send_item(12'd500, stamp_ms + 32'd550, 1'b0);
    stamp_ms = stamp_ms + 32'd550;
    send_item(12'd4095, stamp_ms, 1'b0);
    send_item(12'd3000, stamp_ms, 1'b0);
    send_item(12'd2000, stamp_ms, 1'b0);
    send_item(12'd4095, stamp_ms + 32'd1, 1'b0);
    send_item(12'd0, stamp_ms + 32'd2, 1'b1);
    send_item(12'd4095, stamp_ms + 32'd2, 1'b0);
    send_item(12'd1001, stamp_ms + 32'd3, 1'b0);
    send_item(12'd2999, stamp_ms + 32'd4, 1'b0);
    wait_idle();

    // Inverted axis with overlapping zones and zero delay and period: a reading in
    // both zones means up, and a held direction steps on every item.
    program_regs(12'd3000, 12'd1000, 1'b1, 16'd0, 16'd0);
    send_item(12'd2000, 32'd7, 1'b0);
    send_item(12'd2000, 32'd7, 1'b0);
    send_item(12'd2000, 32'd7, 1'b0);
    send_item(12'd4095, 32'd8, 1'b0);
    send_item(12'd0, 32'd9, 1'b0);
    send_item(12'd0, 32'd9, 1'b0);
    send_item(12'd4095, 32'hFFFF_FFFF, 1'b1);
    send_item(12'd0, 32'hFFFF_FFFF, 1'b0);
    send_item(12'd3500, 32'd0, 1'b0);
    wait_idle();

    // Register extremes first, then random settings; the sender waits for the block
    // to drain before every reprogramming.
    stamp_ms = 32'd0;
    program_regs(12'd0, 12'd4095, 1'b0, 16'hFFFF, 16'hFFFF);
    run_phase(250);
    wait_idle();
    program_regs(12'd4095, 12'd0, 1'b1, 16'd0, 16'd0);
    run_phase(250);
    wait_idle();
    program_regs(12'd4095, 12'd4095, 1'b0, 16'd1, 16'hFFFF);
    run_phase(250);
    wait_idle();
    program_regs(12'd0, 12'd0, 1'b1, 16'hFFFF, 16'd1);
    run_phase(250);
    wait_idle();
    repeat (3) begin
      program_regs(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   1'($urandom_range(0, 1)),
                   ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 600))
                                                : 16'($urandom()),
                   ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 300))
                                                : 16'($urandom()));
      run_phase(250);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run of the stimulus above.
  initial begin
    #6000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== axis_auto_repeat_stepper.f =====
sv/asr_pkg.sv
sv/asr_classify.sv
sv/asr_engine.sv
sv/axis_auto_repeat_stepper.sv
tb/tb_axis_auto_repeat_stepper.sv
